/* hdl/pli_pkg.sv */
// Shared constants, codes and types for the positional list block.
`default_nettype none
package pli_pkg;

   localparam int DEPTH       = 16;
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CMP_W       = (CNT_W > 5) ? CNT_W : 5;

   localparam int CMD_W    = 3;
   localparam int POS_W    = 5;
   localparam int VAL_W    = 32;
   localparam int STAT_W   = 3;
   localparam int FPOS_W   = 4;
   localparam int FILL_W   = 5;
   localparam int CAP_W    = 5;
   localparam int REQ_TD_W = 40;
   localparam int RSP_TD_W = 48;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 3'd0,
      CMD_ERASE  = 3'd1,
      CMD_READ   = 3'd2,
      CMD_FIND   = 3'd3,
      CMD_DUMP   = 3'd4
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_BADPOS   = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic                    ins;
      logic                    ers;
      logic [POS_W-1:0]        pos;
      logic signed [VAL_W-1:0] value;
   } cell_ctrl_type;

endpackage
`default_nettype wire

/* hdl/pli_cell.sv */
// One list cell: holds a word, shifts from a neighbor, compares to the key.
`default_nettype none
module pli_cell (
   input  wire logic                            clock,
   input  wire pli_pkg::cell_ctrl_type          ctrl,
   input  wire logic [pli_pkg::IDX_W-1:0]       idx,
   input  wire logic signed [pli_pkg::VAL_W-1:0] left_data,
   input  wire logic signed [pli_pkg::VAL_W-1:0] right_data,
   output logic signed [pli_pkg::VAL_W-1:0]     data,
   output logic                                 match
);

   logic signed [pli_pkg::VAL_W-1:0] entry_ff, entry_in;
   logic                             match_ff, match_in;
   logic                             above, at;

   always_comb begin
      above    = pli_pkg::CMP_W'(idx) > pli_pkg::CMP_W'(ctrl.pos);
      at       = pli_pkg::CMP_W'(idx) == pli_pkg::CMP_W'(ctrl.pos);
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (above) entry_in = left_data;
         else if (at) entry_in = ctrl.value;
      end else if (ctrl.ers) begin
         if (above || at) entry_in = right_data;
      end
      match_in = (entry_ff == ctrl.value);
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign data  = entry_ff;
   assign match = match_ff;

endmodule
`default_nettype wire

/* hdl/positional_list_insert_erase.sv */
// Top level: positional list of signed words built as a row of shifting cells.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | cmd, position, value
//  rsp     | out | rsp_tvalid/tready    | status, data_out, found_position, fill_count, tlast
//  csr     | in  | csr_we (no stall)    | capacity
//
// Insert, erase and read: every cell shifts or holds in parallel as the result is registered.
// Find: the cells register their compare, then a priority pick loads the result register.
// Dump emits min(count, 16) words in position order, each once the result register is free.
// A stalled response holds the block; one result register sits between the sides.
// Synchronous reset empties the list and sets capacity to 16; no clearing pass.
`default_nettype none
module positional_list_insert_erase (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // cmd[2:0], position[7:3], value[39:8]
   input  wire logic [pli_pkg::REQ_TD_W-1:0]  req_tdata,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // status[2:0], data_out[34:3], found_position[38:35], fill_count[43:39], zero pad
   output logic [pli_pkg::RSP_TD_W-1:0]       rsp_tdata,
   output logic                               rsp_tlast,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   input  wire logic                          csr_we,
   input  wire logic [pli_pkg::CAP_W-1:0]     csr_wdata
);

   typedef enum logic [1:0] {S_IDLE, S_FIND, S_DUMP} state_type;

   localparam int CW = pli_pkg::CMP_W;

   state_type                          state_ff, state_in;
   logic [pli_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [pli_pkg::CAP_W-1:0]          cap_ff, cap_in;
   logic [pli_pkg::IDX_W-1:0]          idx_ff, idx_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   pli_pkg::status_type                rsp_status_ff, rsp_status_in;
   logic signed [pli_pkg::VAL_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [pli_pkg::FPOS_W-1:0]         rsp_fpos_ff, rsp_fpos_in;
   logic [pli_pkg::FILL_W-1:0]         rsp_fill_ff, rsp_fill_in;
   logic                               rsp_last_ff, rsp_last_in;

   // request fields
   logic [pli_pkg::CMD_W-1:0]          req_cmd;
   logic [pli_pkg::POS_W-1:0]          req_pos;
   logic signed [pli_pkg::VAL_W-1:0]   req_value;

   pli_pkg::cell_ctrl_type             ctrl;
   logic signed [pli_pkg::VAL_W-1:0]   entry_w [pli_pkg::DEPTH];
   logic [pli_pkg::DEPTH-1:0]          match_w;

   logic accept, out_free;
   logic is_full, ins_bad, ers_bad;
   logic hit;
   logic [pli_pkg::IDX_W-1:0] hit_idx;
   logic [CW-1:0] dump_n;
   logic dump_last;

   assign req_cmd   = req_tdata[2:0];
   assign req_pos   = req_tdata[7:3];
   assign req_value = req_tdata[39:8];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   // list checks against the current fill
   always_comb begin
      is_full = (CW'(count_ff) >= CW'(cap_ff)) || (CW'(count_ff) >= CW'(pli_pkg::DEPTH));
      ins_bad = CW'(req_pos) > CW'(count_ff);
      ers_bad = CW'(req_pos) >= CW'(count_ff);
   end

   always_comb begin
      ctrl.ins   = accept && (req_cmd == pli_pkg::CMD_INSERT) && !is_full && !ins_bad;
      ctrl.ers   = accept && (req_cmd == pli_pkg::CMD_ERASE) && !ers_bad;
      ctrl.pos   = req_pos;
      ctrl.value = req_value;
   end

   // the cell row
   for (genvar i = 0; i < pli_pkg::DEPTH; i++) begin : g_cell
      pli_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .idx        (pli_pkg::IDX_W'(i)),
         .left_data  (entry_w[(i == 0) ? 0 : i - 1]),
         .right_data (entry_w[(i == pli_pkg::DEPTH - 1) ? i : i + 1]),
         .data       (entry_w[i]),
         .match      (match_w[i])
      );
   end

   // first valid match, lowest position wins
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = pli_pkg::DEPTH - 1; i >= 0; i--) begin
         if (match_w[i] && (CW'(i) < CW'(count_ff))) begin
            hit     = 1'b1;
            hit_idx = pli_pkg::IDX_W'(i);
         end
      end
   end

   // dump length is clipped to the result limit
   always_comb begin
      dump_n    = (CW'(count_ff) > CW'(pli_pkg::MAX_RESULTS)) ?
                  CW'(pli_pkg::MAX_RESULTS) : CW'(count_ff);
      dump_last = (CW'(idx_ff) + CW'(1)) == dump_n;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cap_in        = csr_we ? csr_wdata : cap_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_fpos_in   = rsp_fpos_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_status_in = pli_pkg::ST_OK;
               rsp_data_in   = '0;
               rsp_fpos_in   = '0;
               rsp_last_in   = 1'b1;
               rsp_valid_in  = 1'b1;
               unique case (req_cmd)
                  pli_pkg::CMD_INSERT: begin
                     if (is_full) rsp_status_in = pli_pkg::ST_FULL;
                     else if (ins_bad) rsp_status_in = pli_pkg::ST_BADPOS;
                     else count_in = count_ff + pli_pkg::CNT_W'(1);
                  end
                  pli_pkg::CMD_ERASE: begin
                     if (count_ff == '0) rsp_status_in = pli_pkg::ST_EMPTY;
                     else if (ers_bad) rsp_status_in = pli_pkg::ST_BADPOS;
                     else count_in = count_ff - pli_pkg::CNT_W'(1);
                  end
                  pli_pkg::CMD_READ: begin
                     if (ers_bad) rsp_status_in = pli_pkg::ST_BADPOS;
                     else rsp_data_in = entry_w[pli_pkg::IDX_W'(req_pos)];
                  end
                  pli_pkg::CMD_FIND: begin
                     rsp_valid_in = 1'b0;
                     state_in     = S_FIND;
                  end
                  pli_pkg::CMD_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_status_in = pli_pkg::ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        idx_in       = '0;
                        state_in     = S_DUMP;
                     end
                  end
                  default: rsp_valid_in = 1'b0;
               endcase
               rsp_fill_in = pli_pkg::FILL_W'(count_in);
            end
         end
         S_FIND: begin
            // result register is known free here
            rsp_valid_in  = 1'b1;
            rsp_status_in = hit ? pli_pkg::ST_OK : pli_pkg::ST_NOTFOUND;
            rsp_data_in   = '0;
            rsp_fpos_in   = hit ? pli_pkg::FPOS_W'(hit_idx) : '0;
            rsp_fill_in   = pli_pkg::FILL_W'(count_ff);
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end
         S_DUMP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pli_pkg::ST_OK;
               rsp_data_in   = entry_w[idx_ff];
               rsp_fpos_in   = pli_pkg::FPOS_W'(idx_ff);
               rsp_fill_in   = pli_pkg::FILL_W'(count_ff);
               rsp_last_in   = dump_last;
               if (dump_last) state_in = S_IDLE;
               else idx_in = idx_ff + pli_pkg::IDX_W'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= pli_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_fpos_ff   <= rsp_fpos_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0000, rsp_fill_ff, rsp_fpos_ff, rsp_data_ff, rsp_status_ff};

endmodule
`default_nettype wire

/* hdl/pli_checker.sv */
// Port-level checks for the positional list, bound to the top level.
`default_nettype none
module pli_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_tvalid,
   input wire logic                         req_tready,
   input wire logic [pli_pkg::RSP_TD_W-1:0] rsp_tdata,
   input wire logic                         rsp_tlast,
   input wire logic                         rsp_tvalid,
   input wire logic                         rsp_tready
);

   logic [pli_pkg::STAT_W-1:0] status;
   assign status = rsp_tdata[2:0];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_idle_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status != pli_pkg::ST_OK) |-> rsp_tlast && (rsp_tdata[38:3] == '0))
      else $error("error response not final or carries data");

   a_dump_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !(req_tvalid && req_tready))
      else $error("request taken in the middle of a dump");

endmodule

bind positional_list_insert_erase pli_checker u_pli_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
`default_nettype wire

/* verif/pli_list_checker.sv */
// Checker for the positional list: tracks the list, predicts each result, compares it.
module pli_list_checker
   import pli_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [REQ_TD_W-1:0] req_tdata,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [RSP_TD_W-1:0] rsp_tdata,
   input  logic                rsp_tlast,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic                csr_we,
   input  logic [CAP_W-1:0]    csr_wdata,
   output int                  fail_count,
   output int                  pending,
   output int                  held_count
);

   // rsp_tdata layout
   localparam int DATA_LSB = STAT_W;
   localparam int FPOS_LSB = DATA_LSB + VAL_W;
   localparam int FILL_LSB = FPOS_LSB + FPOS_W;
   localparam int PAD_LSB  = FILL_LSB + FILL_W;

   typedef struct {
      status_type         status;
      logic [VAL_W-1:0]   data;
      logic [FPOS_W-1:0]  fpos;
      logic [FILL_W-1:0]  fill;
      logic               last;
   } list_result_type;

   logic [VAL_W-1:0] words [DEPTH];
   int               list_len = 0;
   logic [CAP_W-1:0] capacity = CAP_RESET;
   list_result_type  awaited_results [$];

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      fail_count++;
      $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
   endtask

   // fill is taken after the operation has changed the length
   task automatic post_result(input status_type st, input logic [VAL_W-1:0] data,
                              input int at, input bit last);
      list_result_type r;
      r.status = st;
      r.data   = data;
      r.fpos   = at[FPOS_W-1:0];
      r.fill   = list_len[FILL_W-1:0];
      r.last   = last;
      awaited_results.push_back(r);
   endtask

   task automatic apply_list_op(input logic [CMD_W-1:0] op, input int at,
                                input logic [VAL_W-1:0] word);
      int room;
      int n;
      int i;
      int hit;
      room = (capacity > DEPTH) ? DEPTH : int'(capacity);
      case (op)
         CMD_INSERT: begin
            if (list_len >= room) begin
               post_result(ST_FULL, '0, 0, 1'b1);
            end else if (at > list_len) begin
               post_result(ST_BADPOS, '0, 0, 1'b1);
            end else begin
               for (i = list_len; i > at; i--) words[i] = words[i-1];
               words[at] = word;
               list_len++;
               post_result(ST_OK, '0, 0, 1'b1);
            end
         end
         CMD_ERASE: begin
            if (list_len == 0) begin
               post_result(ST_EMPTY, '0, 0, 1'b1);
            end else if (at >= list_len) begin
               post_result(ST_BADPOS, '0, 0, 1'b1);
            end else begin
               for (i = at; i + 1 < list_len; i++) words[i] = words[i+1];
               list_len--;
               post_result(ST_OK, '0, 0, 1'b1);
            end
         end
         CMD_READ: begin
            if (at >= list_len) post_result(ST_BADPOS, '0, 0, 1'b1);
            else post_result(ST_OK, words[at], 0, 1'b1);
         end
         CMD_FIND: begin
            hit = -1;
            for (i = 0; i < list_len && hit < 0; i++)
               if (words[i] === word) hit = i;
            if (hit < 0) post_result(ST_NOTFOUND, '0, 0, 1'b1);
            else post_result(ST_OK, '0, hit, 1'b1);
         end
         CMD_DUMP: begin
            n = (list_len > MAX_RESULTS) ? MAX_RESULTS : list_len;
            if (n == 0) begin
               post_result(ST_EMPTY, '0, 0, 1'b1);
            end else begin
               for (i = 0; i < n; i++) post_result(ST_OK, words[i], i, i == n - 1);
            end
         end
         default: ; // reserved codes are dropped without a result
      endcase
   endtask

   always @(posedge clock) begin : watch
      list_result_type want;
      if (reset) begin
         awaited_results.delete();
         list_len = 0;
         capacity = CAP_RESET;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("transaction with none expected", 64'(rsp_tdata), '0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_tdata[STAT_W-1:0] !== want.status)
                  report_mismatch("status", 64'(rsp_tdata[STAT_W-1:0]),
                                  64'(want.status));
               if (rsp_tdata[DATA_LSB +: VAL_W] !== want.data)
                  report_mismatch("data_out", 64'(rsp_tdata[DATA_LSB +: VAL_W]),
                                  64'(want.data));
               if (rsp_tdata[FPOS_LSB +: FPOS_W] !== want.fpos)
                  report_mismatch("found_position", 64'(rsp_tdata[FPOS_LSB +: FPOS_W]),
                                  64'(want.fpos));
               if (rsp_tdata[FILL_LSB +: FILL_W] !== want.fill)
                  report_mismatch("fill_count", 64'(rsp_tdata[FILL_LSB +: FILL_W]),
                                  64'(want.fill));
               if (rsp_tdata[RSP_TD_W-1:PAD_LSB] !== '0)
                  report_mismatch("pad bits", 64'(rsp_tdata[RSP_TD_W-1:PAD_LSB]), '0);
               if (rsp_tlast !== want.last)
                  report_mismatch("tlast", 64'(rsp_tlast), 64'(want.last));
            end
         end
         if (csr_we) capacity = csr_wdata;
         if (req_tvalid && req_tready)
            apply_list_op(req_tdata[CMD_W-1:0], int'(req_tdata[CMD_W +: POS_W]),
                          req_tdata[CMD_W+POS_W +: VAL_W]);
      end
      pending    <= awaited_results.size();
      held_count <= list_len;
   end

endmodule

/* verif/tb_positional_list_insert_erase.sv */
// Testbench top for the positional list: stimulus, stream pacing, watchdog and verdict.
module tb_positional_list_insert_erase;
   import pli_pkg::*;

   // cmd codes the block must drop without answering
   localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 32;   // 8 x 32 answered random transactions
   // a dump of 16 words plus the find pipeline and the result register
   localparam int SETTLE_CYCLES = 24;
   // longest quiet stretch is the longest pick_gap stall plus a settle pause; this is far above
   localparam int STALL_LIMIT  = 3000;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic [REQ_TD_W-1:0] req_tdata  = '0;
   logic                req_tvalid = 1'b0;
   wire                 req_tready;
   wire [RSP_TD_W-1:0]  rsp_tdata;
   wire                 rsp_tlast;
   wire                 rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic                csr_we     = 1'b0;
   logic [CAP_W-1:0]    csr_wdata  = '0;

   int fail_count;
   int pending;
   int held_count;

   bit        steady      = 1'b0;   // no gaps on either side while set
   int        insert_pct  = 35;     // share of inserts in the random mix
   int        idle_cycles = 0;
   bit [31:0] recent_words [8];     // last inserted words, reused as find keys
   int        recent_wr   = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   positional_list_insert_erase u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   pli_list_checker u_list_check (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .held_count (held_count)
   );

   // Gap length: mostly none or short, now and then long; none in steady stretches.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady) return 0;
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // One request transaction. tvalid stays high across back-to-back transactions,
   // so it only ever gets one assignment per edge.
   task automatic send_op(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                          input logic [VAL_W-1:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {val, pos, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (op == CMD_INSERT) begin
         recent_words[recent_wr] = val;
         recent_wr = (recent_wr + 1) % 8;
      end
   endtask

   // Stop sending until every expected result is back, then let a dropped
   // reserved-code transaction or a late find work its way out.
   // The first edge lets the checker count the transaction just accepted.
   task automatic drain_list();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      csr_wdata <= cap;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Random transaction. Positions mostly fall on or just past the held words so
   // inserts and erases land; keys mix tiny values (duplicates), recent inserts
   // (find hits) and full-range words.
   task automatic send_random_op(output bit counted);
      int               r;
      logic [CMD_W-1:0] op;
      logic [POS_W-1:0] pos;
      logic [VAL_W-1:0] val;
      r = $urandom_range(0, 99);
      if (r < insert_pct) begin
         op = CMD_INSERT;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 30)      op = CMD_ERASE;
         else if (r < 52) op = CMD_READ;
         else if (r < 76) op = CMD_FIND;
         else if (r < 95) op = CMD_DUMP;
         else             op = CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
      end
      if ($urandom_range(0, 3) != 0) pos = POS_W'($urandom_range(0, held_count));
      else pos = POS_W'($urandom_range(0, 31));
      case ($urandom_range(0, 2))
         0:       val = $urandom_range(0, 7) - 4;
         1:       val = recent_words[$urandom_range(0, 7)];
         default: val = $urandom;
      endcase
      send_op(op, pos, val);
      counted = (op <= CMD_DUMP);
   endtask

   // Result side: tready drops for random stretches, independent of the sender.
   initial begin : rsp_pacing
      int hold;
      forever begin
         hold = pick_gap();
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Watchdog: a long run of edges with no transaction on either channel means a hang.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stimulus
      logic [CAP_W-1:0] cap_plan [PHASES];
      int               ph;
      int               done_in_phase;
      bit               counted;

      // capacity per phase: reset value, one word, zero, above the built depth,
      // a cut below what is held, just above depth, back to depth, then random
      cap_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd17, 5'd16, 5'd0};
      cap_plan[PHASES-1] = CAP_W'($urandom_range(0, 31));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // --- directed: empty-list answers, signed extremes, duplicates, bad positions
      send_op(CMD_READ,   5'd0,  32'h0);          // read from empty list
      send_op(CMD_ERASE,  5'd0,  32'h0);          // erase from empty list
      send_op(CMD_FIND,   5'd0,  32'h0);          // find in empty list
      send_op(CMD_DUMP,   5'd0,  32'h0);          // dump of empty list
      send_op(CMD_INSERT, 5'd1,  32'h1);          // insert past the end
      send_op(CMD_INSERT, 5'd0,  32'h7fff_ffff);
      send_op(CMD_INSERT, 5'd0,  32'h8000_0000);  // front insert shifts up
      send_op(CMD_INSERT, 5'd2,  32'hffff_ffff);  // append at count
      send_op(CMD_INSERT, 5'd1,  32'h0);          // middle insert
      send_op(CMD_INSERT, 5'd4,  32'hffff_ffff);  // duplicate word
      send_op(CMD_FIND,   5'd0,  32'hffff_ffff);  // first of two matches
      send_op(CMD_FIND,   5'd0,  32'd12345);      // no match
      send_op(CMD_READ,   5'd0,  32'h0);
      send_op(CMD_READ,   5'd4,  32'h0);
      send_op(CMD_READ,   5'd5,  32'h0);          // read at count
      send_op(CMD_READ,   5'd31, 32'h0);          // widest position
      send_op(CMD_DUMP,   5'd0,  32'h0);
      send_op(CMD_ERASE,  5'd5,  32'h0);          // erase at count
      send_op(CMD_ERASE,  5'd31, 32'h0);          // erase far out of range
      send_op(CMD_ERASE,  5'd0,  32'h0);          // front erase shifts down
      send_op(CMD_ERASE,  5'd3,  32'h0);          // erase the last word
      send_op(CMD_RSVD5,  POS_W'($urandom_range(0, 31)), $urandom);  // dropped codes
      send_op(CMD_RSVD6,  POS_W'($urandom_range(0, 31)), $urandom);
      send_op(CMD_RSVD7,  POS_W'($urandom_range(0, 31)), $urandom);
      send_op(CMD_DUMP,   5'd0,  32'h0);

      // --- random phases, capacity rewritten only with the block idle
      for (ph = 0; ph < PHASES; ph++) begin
         drain_list();
         write_capacity(cap_plan[ph]);
         steady     = (ph == 3 || ph == 6);
         insert_pct = (ph == 0 || ph == 3 || ph == 5) ? 65 : 35;
         done_in_phase = 0;
         while (done_in_phase < PHASE_ITEMS) begin
            send_random_op(counted);
            if (counted) begin
               done_in_phase++;
               // one mid-phase full stop with results still flowing back
               if (ph == 5 && done_in_phase == PHASE_ITEMS / 2) drain_list();
            end
         end
      end

      drain_list();
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
